@@ rtl/core/dsik_pkg.sv @@
// Package for the two-wheel steering inverse kinematics core.
// Payload structs, CORDIC constants and shared helpers; no dependencies.
package dsik_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int VEC_W = 40;   // Q.20 wheel vector with growth headroom
   localparam int ANG_W = 34;   // Q.30 angle, signed

   localparam logic [1:0] CSR_WHEEL_BASE = 2'd0;
   localparam logic [1:0] CSR_INV_RADIUS = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   localparam logic signed [ANG_W-1:0] ANG_PI    = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] ANG_FOLD  = 34'sd2223500625;
   localparam logic [29:0]             GAIN_COMP = 30'd652032874;

   typedef struct packed {
      logic signed [15:0] lin_x;
      logic signed [15:0] lin_y;
      logic signed [15:0] yaw_rate;
      logic [15:0]        command_age;
   } req_type;

   typedef struct packed {
      logic signed [15:0] front_steer_angle;
      logic signed [23:0] front_wheel_rate;
      logic signed [15:0] rear_steer_angle;
      logic signed [23:0] rear_wheel_rate;
      logic               timed_out;
   } rsp_type;

   // State carried along the cell row for one wheel.
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } wheel_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
      logic signed [ANG_W-1:0] t;
      case (i)
         0:  t = 34'sd843314856;
         1:  t = 34'sd497837829;
         2:  t = 34'sd263043836;
         3:  t = 34'sd133525158;
         4:  t = 34'sd67021686;
         5:  t = 34'sd33543515;
         6:  t = 34'sd16775850;
         7:  t = 34'sd8388437;
         8:  t = 34'sd4194282;
         9:  t = 34'sd2097149;
         10: t = 34'sd1048575;
         11: t = 34'sd524287;
         12: t = 34'sd262143;
         13: t = 34'sd131071;
         14: t = 34'sd65535;
         15: t = 34'sd32767;
         16: t = 34'sd16383;
         17: t = 34'sd8191;
         18: t = 34'sd4095;
         19: t = 34'sd2047;
         20: t = 34'sd1023;
         21: t = 34'sd511;
         22: t = 34'sd255;
         default: t = 34'sd127;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/core/dsik_cell.sv @@
// One CORDIC vectoring cell for both wheels: a micro-rotation and a register.
// Depends on dsik_pkg.
module dsik_cell import dsik_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] stage,
   input  wheel_type  front_in,
   input  wheel_type  rear_in,
   output wheel_type  front_out,
   output wheel_type  rear_out
);

   wheel_type front_ff, rear_ff, front_in_v, rear_in_v;

   // stage is tied to a constant per cell, so the shifts and table reduce to wiring
   function automatic wheel_type rotate(input wheel_type w, input logic [4:0] s);
      wheel_type r;
      r = w;
      if (w.y >= 0) begin
         r.x = w.x + (w.y >>> s);
         r.y = w.y - (w.x >>> s);
         r.z = w.z + atan_entry(int'(s));
      end else begin
         r.x = w.x - (w.y >>> s);
         r.y = w.y + (w.x >>> s);
         r.z = w.z - atan_entry(int'(s));
      end
      return r;
   endfunction

   always_comb begin
      front_in_v = rotate(front_in, stage);
      rear_in_v  = rotate(rear_in, stage);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in_v;
         rear_ff  <= rear_in_v;
      end
   end

   assign front_out = front_ff;
   assign rear_out  = rear_ff;

endmodule

@@ rtl/core/dsik_post.sv @@
// Output cell: fold, gain compensation, rounding and rate scaling.
// Depends on dsik_pkg; two registered steps (gain multiply, rate multiply).
module dsik_post import dsik_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  wheel_type          w_in,
   input  logic [15:0]        inv_radius,
   output logic signed [15:0] angle,
   output logic signed [23:0] rate
);

   logic signed [ANG_W-1:0] z_fold;
   logic                    neg_v;
   logic signed [15:0]      angle_v, ang1_ff, ang2_ff;
   logic                    neg1_ff, neg2_ff, zero1_ff, zero2_ff;
   logic [57:0]             gain_prod;
   logic [39:0]             speed_ff;
   logic [39:0]             speed_v;
   logic [56:0]             rate_prod_ff;
   logic [56:0]             mag;
   logic signed [ANG_W-1:0] z_rnd;

   always_comb begin
      z_fold = w_in.z;
      neg_v  = 1'b0;
      if (w_in.z > ANG_FOLD) begin
         z_fold = w_in.z - ANG_PI;
         neg_v  = 1'b1;
      end else if (w_in.z < -ANG_FOLD) begin
         z_fold = w_in.z + ANG_PI;
         neg_v  = 1'b1;
      end
      z_rnd   = (z_fold + 34'sd65536) >>> 17;
      angle_v = z_rnd[15:0];
      // x is non-negative after vectoring and stays below 2^27
      gain_prod = {30'd0, w_in.x[27:0]} * {28'd0, GAIN_COMP};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang1_ff  <= angle_v;
         neg1_ff  <= neg_v;
         zero1_ff <= w_in.zero;
         speed_ff <= 40'((gain_prod + 58'(1 << 29)) >> 30);
      end
   end

   assign speed_v = speed_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ang2_ff      <= ang1_ff;
         neg2_ff      <= neg1_ff;
         zero2_ff     <= zero1_ff;
         rate_prod_ff <= {17'd0, speed_v} * {41'd0, inv_radius};
      end
   end

   always_comb begin
      mag = (rate_prod_ff + 57'd32768) >> 16;
      if (zero2_ff) begin
         angle = '0;
         rate  = '0;
      end else begin
         angle = ang2_ff;
         if (neg2_ff)
            rate = (mag >= 57'd8388608) ? 24'sh800000 : -$signed(mag[23:0]);
         else
            rate = (mag > 57'd8388607) ? 24'sh7FFFFF : $signed(mag[23:0]);
      end
   end

endmodule

@@ rtl/core/dual_steer_inverse_kinematics_core.sv @@
// Two-wheel steering inverse kinematics: accepts one command per cycle while
// the output is not stalled and presents wheel angles and rates through the
// input register, one cell per CORDIC stage, two multiply steps in the output
// cell and the output register. The pipeline advances whenever the output
// register is empty or being taken; a stalled result holds every stage.
module dual_steer_inverse_kinematics_core import dsik_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH = CORDIC_STAGES + 3;

   logic [14:0] wheel_base_ff;
   logic [15:0] inv_radius_ff, timeout_ff;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] tout_ff;
   logic             adv;
   logic             tout_v;
   logic signed [31:0] yaw_prod;
   logic signed [VEC_W-1:0] half, vx, vy;
   wheel_type f0, r0;
   wheel_type fc [CORDIC_STAGES+1];
   wheel_type rc [CORDIC_STAGES+1];
   logic signed [15:0] fa, ra;
   logic signed [23:0] fr, rr;
   rsp_type rsp_ff;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_base_ff <= 15'd4096;
         inv_radius_ff <= 16'd2560;
         timeout_ff    <= 16'd500;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WHEEL_BASE: wheel_base_ff <= csr_wdata[14:0];
            CSR_INV_RADIUS: inv_radius_ff <= csr_wdata;
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input cell: timeout, yaw term, quadrant pre-rotation.
   always_comb begin
      tout_v   = req_data.command_age > timeout_ff;
      yaw_prod = tout_v ? 32'sd0 : req_data.yaw_rate * $signed({1'b0, wheel_base_ff});
      half     = VEC_W'((yaw_prod + 32'sd16) >>> 5);
      vx       = tout_v ? '0 : VEC_W'(req_data.lin_x) <<< 8;
      vy       = tout_v ? '0 : VEC_W'(req_data.lin_y) <<< 8;
   end

   function automatic wheel_type prep(input logic signed [VEC_W-1:0] x,
                                      input logic signed [VEC_W-1:0] y);
      wheel_type w;
      w.x = x;
      w.y = y;
      w.z = '0;
      w.zero = (x == 0) && (y == 0);
      if (x < 0) begin
         w.z = (y >= 0) ? ANG_PI : -ANG_PI;
         w.x = -x;
         w.y = -y;
      end
      return w;
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         f0 <= prep(vx, vy + half);
         r0 <= prep(vx, vy - half);
      end
   end

   assign fc[0] = f0;
   assign rc[0] = r0;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      dsik_cell u_cell (
         .clock(clock), .en(adv), .stage(5'(i)),
         .front_in(fc[i]), .rear_in(rc[i]),
         .front_out(fc[i+1]), .rear_out(rc[i+1])
      );
   end

   dsik_post u_post_f (.clock(clock), .en(adv), .w_in(fc[CORDIC_STAGES]),
      .inv_radius(inv_radius_ff), .angle(fa), .rate(fr));
   dsik_post u_post_r (.clock(clock), .en(adv), .w_in(rc[CORDIC_STAGES]),
      .inv_radius(inv_radius_ff), .angle(ra), .rate(rr));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         vld_ff    <= {vld_ff[DEPTH-2:0], req_valid};
         rsp_valid <= vld_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tout_ff <= {tout_ff[DEPTH-2:0], tout_v};
         rsp_ff  <= '{fa, fr, ra, rr, tout_ff[DEPTH-1]};
      end
   end

   assign rsp_data = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[DEPTH-1] |=> rsp_valid)
      else $error("transaction lost at output");

endmodule
